FILE: src/kraq_pkg.sv
// Package for the knob rotation and press qualifier.
// Holds item structs, configuration struct, event codes and register indexes.
// Used by every module of the block; depends on nothing.
package kraq_pkg;

    localparam int unsigned ADDR_W = 5;
    localparam int unsigned DATA_W = 32;

    localparam logic [2:0] REG_ROTATE_MIN   = 3'd0;
    localparam logic [2:0] REG_BTN_PERIOD   = 3'd1;
    localparam logic [2:0] REG_LONG_COUNT   = 3'd2;
    localparam logic [2:0] REG_SHORT_LIMIT  = 3'd3;
    localparam logic [2:0] REG_LOCKOUT      = 3'd4;

    localparam logic [1:0] ROT_NONE = 2'd0;
    localparam logic [1:0] ROT_CW   = 2'd1;
    localparam logic [1:0] ROT_CCW  = 2'd2;

    localparam logic [1:0] BTN_NONE  = 2'd0;
    localparam logic [1:0] BTN_SHORT = 2'd1;
    localparam logic [1:0] BTN_LONG  = 2'd2;

    localparam logic [7:0]  TURN_MAX  = 8'd255;
    localparam logic [11:0] PRESS_MAX = 12'd4095;

    localparam logic [7:0]  RST_ROTATE_MIN  = 8'd4;
    localparam logic [7:0]  RST_BTN_PERIOD  = 8'd10;
    localparam logic [11:0] RST_LONG_COUNT  = 12'd300;
    localparam logic [11:0] RST_SHORT_LIMIT = 12'd250;
    localparam logic [9:0]  RST_LOCKOUT     = 10'd50;

    typedef struct packed {
        logic pin_a;
        logic pin_b;
        logic pin_push;
    } t_in_item;

    typedef struct packed {
        logic [1:0] rotate_event;
        logic [1:0] button_event;
    } t_out_item;

    typedef struct packed {
        logic [7:0]  rotate_min_ticks;
        logic [7:0]  button_period_ticks;
        logic [11:0] long_press_count;
        logic [11:0] short_press_limit;
        logic [9:0]  lockout_ticks;
    } t_cfg;

endpackage

FILE: src/kraq_regs.sv
// Configuration registers of the knob qualifier behind an APB-style port.
// Depends on kraq_pkg.
module kraq_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [kraq_pkg::ADDR_W-1:0] paddr,
    input  logic [kraq_pkg::DATA_W-1:0] pwdata,
    output logic [kraq_pkg::DATA_W-1:0] prdata,
    output kraq_pkg::t_cfg             o_cfg
);
    import kraq_pkg::*;

    t_cfg       r_cfg;
    logic [2:0] w_index;
    logic       w_write;

    assign w_index = paddr[ADDR_W-1:2];
    assign w_write = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rotate_min_ticks    <= RST_ROTATE_MIN;
            r_cfg.button_period_ticks <= RST_BTN_PERIOD;
            r_cfg.long_press_count    <= RST_LONG_COUNT;
            r_cfg.short_press_limit   <= RST_SHORT_LIMIT;
            r_cfg.lockout_ticks       <= RST_LOCKOUT;
        end else if (w_write) begin
            case (w_index)
                REG_ROTATE_MIN:  r_cfg.rotate_min_ticks    <= pwdata[7:0];
                REG_BTN_PERIOD:  r_cfg.button_period_ticks <= pwdata[7:0];
                REG_LONG_COUNT:  r_cfg.long_press_count    <= pwdata[11:0];
                REG_SHORT_LIMIT: r_cfg.short_press_limit   <= pwdata[11:0];
                REG_LOCKOUT:     r_cfg.lockout_ticks       <= pwdata[9:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (w_index)
            REG_ROTATE_MIN:  prdata = {24'd0, r_cfg.rotate_min_ticks};
            REG_BTN_PERIOD:  prdata = {24'd0, r_cfg.button_period_ticks};
            REG_LONG_COUNT:  prdata = {20'd0, r_cfg.long_press_count};
            REG_SHORT_LIMIT: prdata = {20'd0, r_cfg.short_press_limit};
            REG_LOCKOUT:     prdata = {22'd0, r_cfg.lockout_ticks};
            default:         prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

FILE: src/kraq_core.sv
// Per-tick state update of the knob qualifier: edge detect, rotation timer,
// button timer and edge lockout. Depends on kraq_pkg.
module kraq_core (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_advance,
    input  kraq_pkg::t_in_item   i_item,
    input  kraq_pkg::t_cfg       i_cfg,
    output kraq_pkg::t_out_item  o_result
);
    import kraq_pkg::*;

    logic        r_a_last, n_a_last;
    logic        r_push_last, n_push_last;
    logic        r_cw, n_cw;
    logic        r_ccw, n_ccw;
    logic [7:0]  r_turn, n_turn;
    logic        r_btn, n_btn;
    logic [11:0] r_press, n_press;
    logic [7:0]  r_presc, n_presc;
    logic        r_en, n_en;
    logic [9:0]  r_lock, n_lock;

    logic        a, b, p;
    logic        a_fall, p_fall, locked;
    logic [7:0]  period, presc_inc;
    logic [11:0] press_inc;
    logic [1:0]  rot, btn;

    assign a = i_item.pin_a;
    assign b = i_item.pin_b;
    assign p = i_item.pin_push;

    always_comb begin
        a_fall      = r_a_last & ~a;
        p_fall      = r_push_last & ~p;
        n_a_last    = a;
        n_push_last = p;
        n_cw        = r_cw;
        n_ccw       = r_ccw;
        n_turn      = r_turn;
        n_btn       = r_btn;
        n_press     = r_press;
        n_presc     = r_presc;
        n_en        = r_en;
        rot         = ROT_NONE;
        btn         = BTN_NONE;
        period      = (i_cfg.button_period_ticks == 8'd0) ? 8'd1
                                                          : i_cfg.button_period_ticks;
        presc_inc   = r_presc + 8'd1;
        press_inc   = (r_press == PRESS_MAX) ? r_press : r_press + 12'd1;

        // rotation timer: count while the direction's pattern holds
        if (r_cw) begin
            if (b && !a) begin
                n_turn = (r_turn == TURN_MAX) ? r_turn : r_turn + 8'd1;
            end else begin
                n_cw   = 1'b0;
                rot    = (r_turn > i_cfg.rotate_min_ticks) ? ROT_CW : ROT_NONE;
                n_turn = '0;
            end
        end else if (r_ccw) begin
            if (!b && !a) begin
                n_turn = (r_turn == TURN_MAX) ? r_turn : r_turn + 8'd1;
            end else begin
                n_ccw  = 1'b0;
                rot    = (r_turn > i_cfg.rotate_min_ticks) ? ROT_CCW : ROT_NONE;
                n_turn = '0;
            end
        end

        // button timer: check the pin once a period
        if (r_btn) begin
            if (presc_inc >= period) begin
                n_presc = '0;
                if (!p) begin
                    if (press_inc > i_cfg.long_press_count) begin
                        n_press = '0;
                        n_btn   = 1'b0;
                        btn     = BTN_LONG;
                        n_en    = 1'b1;
                    end else begin
                        n_press = press_inc;
                    end
                end else begin
                    // a release in the middle band keeps the timer running
                    if (r_press < i_cfg.short_press_limit) begin
                        n_btn = 1'b0;
                        btn   = BTN_SHORT;
                        n_en  = 1'b1;
                    end
                    n_press = '0;
                end
            end else begin
                n_presc = presc_inc;
            end
        end

        locked = (r_lock != 10'd0) || (rot != ROT_NONE) || (btn != BTN_NONE);
        if ((rot != ROT_NONE) || (btn != BTN_NONE)) begin
            n_lock = i_cfg.lockout_ticks;
        end else if (r_lock != 10'd0) begin
            n_lock = r_lock - 10'd1;
        end else begin
            n_lock = r_lock;
        end

        // push edge first, so it can block the A edge of the same tick
        if (!locked) begin
            if (p_fall) begin
                n_btn   = 1'b1;
                n_presc = '0;
                n_en    = 1'b0;
            end
            if (a_fall && n_en) begin
                n_cw   = b;
                n_ccw  = ~b;
                n_turn = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_last    <= 1'b1;
            r_push_last <= 1'b1;
            r_cw        <= 1'b0;
            r_ccw       <= 1'b0;
            r_turn      <= '0;
            r_btn       <= 1'b0;
            r_press     <= '0;
            r_presc     <= '0;
            r_en        <= 1'b1;
            r_lock      <= '0;
        end else if (i_advance) begin
            r_a_last    <= n_a_last;
            r_push_last <= n_push_last;
            r_cw        <= n_cw;
            r_ccw       <= n_ccw;
            r_turn      <= n_turn;
            r_btn       <= n_btn;
            r_press     <= n_press;
            r_presc     <= n_presc;
            r_en        <= n_en;
            r_lock      <= n_lock;
        end
    end

    assign o_result.rotate_event = rot;
    assign o_result.button_event = btn;

endmodule

FILE: src/knob_rotation_and_press_qualifier.sv
// Knob rotation and push-button qualifier. Each item is one 1 ms sample of
// pins A, B and push; each item gives exactly one result item. An item is
// registered on input, its state update is combinational, and the result is
// registered on output. One item is taken every clock unless the output is
// stalled, which holds the input stage. Depends on kraq_pkg.
module knob_rotation_and_press_qualifier (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  kraq_pkg::t_in_item          i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output kraq_pkg::t_out_item         o_out_data,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [kraq_pkg::ADDR_W-1:0] paddr,
    input  logic [kraq_pkg::DATA_W-1:0] pwdata,
    output logic [kraq_pkg::DATA_W-1:0] prdata,
    output logic                        pready
);
    import kraq_pkg::*;

    t_cfg      w_cfg;
    t_in_item  r_stage;
    logic      r_stage_valid;
    t_out_item r_out;
    logic      r_out_valid;
    t_out_item w_result;
    logic      w_out_free, w_advance, w_take;

    assign pready     = 1'b1;
    assign w_out_free = ~r_out_valid | ~i_out_stall;
    assign w_advance  = r_stage_valid & w_out_free;
    assign o_in_stall = r_stage_valid & ~w_out_free;
    assign w_take     = i_in_valid & ~o_in_stall;

    kraq_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .o_cfg   (w_cfg)
    );

    kraq_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (r_stage),
        .i_cfg     (w_cfg),
        .o_result  (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage_valid <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (w_take) begin
                r_stage_valid <= 1'b1;
            end else if (w_advance) begin
                r_stage_valid <= 1'b0;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: load stage on take, hold result under stall
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_stage <= i_in_data;
        end
        if (w_advance) begin
            r_out <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: src/kraq_checker.sv
// Port-level checks for the knob qualifier, bound to the top level.
// Depends on kraq_pkg.
module kraq_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input kraq_pkg::t_in_item          i_in_data,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input kraq_pkg::t_out_item         o_out_data,
    input logic                        pready
);
    import kraq_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result item changed under stall");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> i_out_stall && o_out_valid)
        else $error("input stalled without output backpressure");

    a_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.rotate_event != 2'd3)
                     && (o_out_data.button_event != 2'd3))
        else $error("undefined event code");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("handshake not cleared by reset");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready dropped");

endmodule

bind knob_rotation_and_press_qualifier kraq_checker u_kraq_checker (.*);

FILE: tb/kraq_event_checker.sv
`timescale 1ns / 1ps
// Event checker for the knob rotation and press qualifier: follows register
// writes, predicts one event item per accepted pin sample and compares it with
// the block's output. Depends on kraq_pkg.
module kraq_event_checker (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_stall,
    input  kraq_pkg::t_in_item          i_in_data,
    input  logic                        i_out_valid,
    input  logic                        i_out_stall,
    input  kraq_pkg::t_out_item         i_out_data,
    input  logic                        i_psel,
    input  logic                        i_penable,
    input  logic                        i_pwrite,
    input  logic [kraq_pkg::ADDR_W-1:0] i_paddr,
    input  logic [kraq_pkg::DATA_W-1:0] i_pwdata,
    input  logic                        i_pready,
    output int unsigned                 o_pending,
    output int unsigned                 o_fail_count
);
    import kraq_pkg::*;

    t_cfg        cfg;
    logic        a_prev;
    logic        push_prev;
    logic        cw_run;
    logic        ccw_run;
    logic        btn_run;
    logic        turn_ok;
    logic [7:0]  turn_cnt;
    logic [7:0]  prescale;
    logic [11:0] checks;
    logic [9:0]  lock_left;
    t_out_item   expected_events[$];
    t_out_item   want;
    int unsigned errors = 0;

    assign o_fail_count = errors;

    // Advance the knob state by one tick and return the events it reports.
    function automatic t_out_item qualify_tick(input t_in_item smp);
        t_out_item  ev;
        logic       a_fall;
        logic       p_fall;
        logic       locked;
        logic [7:0] period;
        ev.rotate_event = ROT_NONE;
        ev.button_event = BTN_NONE;
        a_fall = a_prev && !smp.pin_a;
        p_fall = push_prev && !smp.pin_push;
        a_prev = smp.pin_a;
        push_prev = smp.pin_push;

        // running timers see this tick's pins before any edge is taken
        if (cw_run) begin
            if (smp.pin_b && !smp.pin_a) begin
                if (turn_cnt != TURN_MAX) turn_cnt = turn_cnt + 8'd1;
            end else begin
                cw_run = 1'b0;
                if (turn_cnt > cfg.rotate_min_ticks) ev.rotate_event = ROT_CW;
                turn_cnt = 8'd0;
            end
        end else if (ccw_run) begin
            if (!smp.pin_b && !smp.pin_a) begin
                if (turn_cnt != TURN_MAX) turn_cnt = turn_cnt + 8'd1;
            end else begin
                ccw_run = 1'b0;
                if (turn_cnt > cfg.rotate_min_ticks) ev.rotate_event = ROT_CCW;
                turn_cnt = 8'd0;
            end
        end

        if (btn_run) begin
            period = (cfg.button_period_ticks == 8'd0) ? 8'd1 : cfg.button_period_ticks;
            prescale = prescale + 8'd1;
            if (prescale >= period) begin
                prescale = 8'd0;
                if (!smp.pin_push) begin
                    if (checks != PRESS_MAX) checks = checks + 12'd1;
                    if (checks > cfg.long_press_count) begin
                        checks = 12'd0;
                        btn_run = 1'b0;
                        ev.button_event = BTN_LONG;
                        turn_ok = 1'b1;
                    end
                end else begin
                    // released in the middle band: clear and keep timing
                    if (checks < cfg.short_press_limit) begin
                        btn_run = 1'b0;
                        ev.button_event = BTN_SHORT;
                        turn_ok = 1'b1;
                    end
                    checks = 12'd0;
                end
            end
        end

        locked = (lock_left != 10'd0) || (ev.rotate_event != ROT_NONE) ||
                 (ev.button_event != BTN_NONE);
        if ((ev.rotate_event != ROT_NONE) || (ev.button_event != BTN_NONE))
            lock_left = cfg.lockout_ticks;
        else if (lock_left != 10'd0)
            lock_left = lock_left - 10'd1;

        if (!locked) begin
            if (p_fall) begin
                btn_run = 1'b1;
                prescale = 8'd0;
                turn_ok = 1'b0;
            end
            if (a_fall && turn_ok) begin
                cw_run = smp.pin_b;
                ccw_run = !smp.pin_b;
                turn_cnt = 8'd0;
            end
        end
        return ev;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.rotate_min_ticks = RST_ROTATE_MIN;
            cfg.button_period_ticks = RST_BTN_PERIOD;
            cfg.long_press_count = RST_LONG_COUNT;
            cfg.short_press_limit = RST_SHORT_LIMIT;
            cfg.lockout_ticks = RST_LOCKOUT;
            a_prev = 1'b1;
            push_prev = 1'b1;
            cw_run = 1'b0;
            ccw_run = 1'b0;
            btn_run = 1'b0;
            turn_ok = 1'b1;
            turn_cnt = 8'd0;
            prescale = 8'd0;
            checks = 12'd0;
            lock_left = 10'd0;
            expected_events.delete();
            o_pending <= 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_events.size() == 0) begin
                    $error("event item with nothing predicted: rotate_event %0d, button_event %0d",
                           i_out_data.rotate_event, i_out_data.button_event);
                    errors = errors + 1;
                end else begin
                    want = expected_events.pop_front();
                    if (i_out_data.rotate_event !== want.rotate_event) begin
                        $error("rotate_event: expected %0d, actual %0d",
                               want.rotate_event, i_out_data.rotate_event);
                        errors = errors + 1;
                    end
                    if (i_out_data.button_event !== want.button_event) begin
                        $error("button_event: expected %0d, actual %0d",
                               want.button_event, i_out_data.button_event);
                        errors = errors + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_events.push_back(qualify_tick(i_in_data));
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[ADDR_W-1:2])
                    REG_ROTATE_MIN:  cfg.rotate_min_ticks = i_pwdata[7:0];
                    REG_BTN_PERIOD:  cfg.button_period_ticks = i_pwdata[7:0];
                    REG_LONG_COUNT:  cfg.long_press_count = i_pwdata[11:0];
                    REG_SHORT_LIMIT: cfg.short_press_limit = i_pwdata[11:0];
                    REG_LOCKOUT:     cfg.lockout_ticks = i_pwdata[9:0];
                    default: ;
                endcase
            end
            o_pending <= expected_events.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Top of the knob qualifier testbench: clock, reset, pin sample and register
// stimulus with random idling and back-pressure, and the verdict.
// Depends on kraq_pkg, knob_rotation_and_press_qualifier and kraq_event_checker.
module tb_top;
    import kraq_pkg::*;

    localparam int unsigned HOLD_OFF_CYCLES = 64;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    t_in_item          i_in_data = '1;
    logic              o_in_stall;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    t_out_item         o_out_data;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int unsigned pending;
    int unsigned fail_count;
    int unsigned ticks_sent = 0;
    bit          quiet = 1'b0;
    bit          hold_off = 1'b0;
    logic        push_lvl = 1'b1;
    logic [7:0]  cur_period;
    logic [11:0] cur_long;
    logic [9:0]  cur_lock;

    knob_rotation_and_press_qualifier dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    kraq_event_checker u_event_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_stall   (o_in_stall),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .i_out_data   (o_out_data),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Receiver: random stall, or one long hold-off when asked.
    initial begin
        forever begin
            @(posedge i_clk);
            if (hold_off) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
                hold_off = 1'b0;
            end else begin
                i_out_stall <= !quiet && ($urandom_range(99) < 32);
            end
        end
    end

    task automatic send_tick(input logic a, input logic b, input logic p);
        t_in_item smp;
        smp.pin_a = a;
        smp.pin_b = b;
        smp.pin_push = p;
        while (!quiet && ($urandom_range(99) < 32)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= smp;
        do @(posedge i_clk); while (o_in_stall);
        ticks_sent = ticks_sent + 1;
    endtask

    task automatic idle_ticks(input int unsigned n);
        repeat (n) send_tick(1'b1, 1'($urandom_range(1)), push_lvl);
    endtask

    // A falls with B at the direction's level, pattern held len ticks, then broken.
    task automatic turn(input logic cw, input int unsigned len);
        send_tick(1'b1, 1'($urandom_range(1)), push_lvl);
        repeat (len + 1) send_tick(1'b0, cw, push_lvl);
        if ($urandom_range(1)) send_tick(1'b1, cw, push_lvl);
        else send_tick(1'b0, !cw, push_lvl);
    endtask

    task automatic press(input int unsigned hold, input int unsigned rel);
        push_lvl = 1'b0;
        repeat (hold) send_tick($urandom_range(3) != 0, 1'($urandom_range(1)), 1'b0);
        push_lvl = 1'b1;
        repeat (rel) send_tick(1'b1, 1'($urandom_range(1)), 1'b1);
    endtask

    // Hold the sender until every predicted event item has come back.
    task automatic drain_events();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic set_config(input logic [7:0] rot_min, input logic [7:0] period,
                              input logic [11:0] long_cnt, input logic [11:0] short_lim,
                              input logic [9:0] lock);
        drain_events();
        write_reg(REG_ROTATE_MIN, {24'd0, rot_min});
        write_reg(REG_BTN_PERIOD, {24'd0, period});
        write_reg(REG_LONG_COUNT, {20'd0, long_cnt});
        write_reg(REG_SHORT_LIMIT, {20'd0, short_lim});
        write_reg(REG_LOCKOUT, {22'd0, lock});
        cur_period = period;
        cur_long = long_cnt;
        cur_lock = lock;
    endtask

    task automatic random_phase(input int unsigned n);
        int unsigned stop;
        int unsigned per;
        int unsigned len;
        stop = ticks_sent + n;
        while (ticks_sent < stop) begin
            per = (cur_period == 8'd0) ? 1 : cur_period;
            len = ($urandom_range(7) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 8);
            case ($urandom_range(9))
                0, 1, 2, 3: turn(1'($urandom_range(1)), len);
                4, 5, 6: press($urandom_range(0, cur_long + 2) * per + $urandom_range(1, per),
                               per + $urandom_range(0, per));
                7: begin
                    // turn the knob while the button is held
                    push_lvl = 1'b0;
                    turn(1'($urandom_range(1)), len);
                    push_lvl = 1'b1;
                    idle_ticks(2 * per);
                end
                default: begin
                    repeat ($urandom_range(1, 12))
                        send_tick(1'($urandom_range(1)), 1'($urandom_range(1)),
                                  1'($urandom_range(1)));
                end
            endcase
            idle_ticks($urandom_range(0, cur_lock + 2));
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        cur_period = RST_BTN_PERIOD;
        cur_long = RST_LONG_COUNT;
        cur_lock = RST_LOCKOUT;

        // reset settings: push and A falling together, push wins
        send_tick(1'b1, 1'b1, 1'b1);
        send_tick(1'b0, 1'b0, 1'b0);
        idle_ticks(63);
        turn(1'b1, 6);
        idle_ticks(52);
        turn(1'b0, 6);
        idle_ticks(52);
        turn(1'b1, 4);
        idle_ticks(2);
        // press again between checks to restart the prescaler
        press(5, 2);
        press(25, 12);
        idle_ticks(52);

        // zero period, zero rotate minimum, press limits of one, no lockout
        set_config(8'd0, 8'd0, 12'd1, 12'd1, 10'd0);
        turn(1'b1, 1);
        turn(1'b0, 0);
        press(3, 2);
        press(2, 3);
        press(1, 3);

        // saturate the turn counter; release lands in the middle band
        set_config(8'd254, 8'd0, 12'd4095, 12'd2, 10'd0);
        turn(1'b1, 258);
        press(5, 3);

        // largest settings
        set_config(8'd255, 8'd255, 12'd4095, 12'd4095, 10'd1023);
        turn(1'b0, 8);
        press(4, 3);
        idle_ticks(4);

        for (int ph = 0; ph < 4; ph++) begin
            set_config(8'($urandom_range(0, 6)), 8'($urandom_range(0, 4)),
                       12'($urandom_range(1, 10)), 12'($urandom_range(1, 10)),
                       10'($urandom_range(0, 6)));
            quiet = (ph == 1);
            if (ph == 2) hold_off = 1'b1;
            random_phase(30);
        end
        quiet = 1'b0;

        drain_events();
        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
